[hdl/mbps_pkg.sv]
// ----------------------------------------------------------------------------
// Masked byte pattern scanner package
// Shared constants, register indexes and types for the scanner blocks.
// ----------------------------------------------------------------------------
package mbps_pkg;

    // Window depth and largest usable pattern length
    localparam int MAX_PATTERN = 16;
    localparam int FILL_W      = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    // Fixed field widths
    localparam int BYTE_W   = 8;
    localparam int ADDR_W   = 48;
    localparam int CFG_W    = 64;
    localparam int CARE_W   = 16;
    localparam int LENCFG_W = 5;
    localparam int PAT_BYTES = 16;
    localparam int CFG_IDX_W = 2;

    typedef logic [BYTE_W-1:0]    byte_t;
    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [FILL_W-1:0]    fill_t;
    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW    = 2'd0,
        REG_PATTERN_HIGH   = 2'd1,
        REG_CARE_MASK      = 2'd2,
        REG_PATTERN_LENGTH = 2'd3
    } cfg_reg_t;

    // Active pattern setup handed to the match core
    typedef struct packed {
        logic [CFG_W-1:0]  pattern_low;
        logic [CFG_W-1:0]  pattern_high;
        logic [CARE_W-1:0] care_mask;
        fill_t             length;
    } scan_cfg_t;

    // One result transaction
    typedef struct packed {
        logic  found;
        addr_t match_address;
    } result_t;

    // Result push from the match core to the output queue
    typedef struct packed {
        logic    push;
        result_t res;
    } result_push_t;

endpackage

[hdl/mbps_if.sv]
// ----------------------------------------------------------------------------
// Scanner channel interfaces
// Valid/ready channels for the byte stream and the scan results.
// ----------------------------------------------------------------------------
interface mbps_byte_if;
    import mbps_pkg::*;

    logic  valid;
    logic  ready;
    byte_t data_byte;
    addr_t byte_address;
    logic  restart;
    logic  last_byte;

    modport source (output valid, output data_byte, output byte_address,
                    output restart, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input byte_address,
                    input restart, input last_byte, output ready);
endinterface

interface mbps_result_if;
    import mbps_pkg::*;

    logic  valid;
    logic  ready;
    logic  found;
    addr_t match_address;
    logic  last;

    modport source (output valid, output found, output match_address,
                    output last, input ready);
    modport sink   (input valid, input found, input match_address,
                    input last, output ready);
endinterface

[hdl/mbps_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Scanner configuration registers
// Holds pattern, care mask and the clamped pattern length.
// ----------------------------------------------------------------------------
module mbps_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  mbps_pkg::cfg_index_t          cfg_index,
    input  logic [mbps_pkg::CFG_W-1:0]    cfg_data,
    output mbps_pkg::scan_cfg_t           cfg
);
    import mbps_pkg::*;

    logic [CFG_W-1:0]    pattern_low_reg;
    logic [CFG_W-1:0]    pattern_high_reg;
    logic [CARE_W-1:0]   care_mask_reg;
    fill_t               length_reg;
    logic [LENCFG_W-1:0] len_raw;
    fill_t               length_next;

    // Clamp the written length to 1..MAX_PATTERN
    assign len_raw = cfg_data[LENCFG_W-1:0];

    always_comb
    begin
        if (len_raw == '0)
            length_next = fill_t'(1);
        else if (32'(len_raw) > MAX_PATTERN)
            length_next = fill_t'(MAX_PATTERN);
        else
            length_next = fill_t'(len_raw);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            care_mask_reg    <= '1;
            length_reg       <= fill_t'(MAX_PATTERN);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PATTERN_LOW:    pattern_low_reg  <= cfg_data;
                REG_PATTERN_HIGH:   pattern_high_reg <= cfg_data;
                REG_CARE_MASK:      care_mask_reg    <= cfg_data[CARE_W-1:0];
                REG_PATTERN_LENGTH: length_reg       <= length_next;
                default: ;
            endcase
        end
    end

    assign cfg.pattern_low  = pattern_low_reg;
    assign cfg.pattern_high = pattern_high_reg;
    assign cfg.care_mask    = care_mask_reg;
    assign cfg.length       = length_reg;

endmodule

[hdl/mbps_match_core.sv]
// ----------------------------------------------------------------------------
// Scanner match core
// Shift-register window with a parallel masked compare against the pattern.
// ----------------------------------------------------------------------------
module mbps_match_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mbps_pkg::scan_cfg_t     cfg,
    input  logic                    accept,
    input  mbps_pkg::byte_t         data_byte,
    input  mbps_pkg::addr_t         byte_address,
    input  logic                    restart,
    input  logic                    last_byte,
    output mbps_pkg::result_push_t  result
);
    import mbps_pkg::*;

    byte_t window_reg  [MAX_PATTERN];
    byte_t window_next [MAX_PATTERN];
    fill_t fill_reg;
    fill_t fill_next;
    logic  match_seen_reg;

    byte_t pat_byte [MAX_PATTERN];
    logic  pat_care [MAX_PATTERN];
    logic  [MAX_PATTERN-1:0] pos_ok;
    logic  hit;
    fill_t base;

    // Pattern bytes beyond the sixteen programmable ones are wildcards
    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            if (k < PAT_BYTES)
            begin
                pat_byte[k] = (k < 8) ? cfg.pattern_low[(k % 8) * 8 +: 8]
                                      : cfg.pattern_high[(k % 8) * 8 +: 8];
                pat_care[k] = cfg.care_mask[k % PAT_BYTES];
            end
            else
            begin
                pat_byte[k] = '0;
                pat_care[k] = 1'b0;
            end
        end
    end

    // Shift in the new byte; window[0] is the newest
    always_comb
    begin
        window_next[0] = data_byte;
        for (int j = 1; j < MAX_PATTERN; j++)
            window_next[j] = window_reg[j-1];
    end

    always_comb
    begin
        if (restart)
            fill_next = fill_t'(1);
        else if (32'(fill_reg) < MAX_PATTERN)
            fill_next = fill_reg + fill_t'(1);
        else
            fill_next = fill_reg;
    end

    // Window slot j lines up with pattern byte length-1-j
    assign base = cfg.length - fill_t'(1);

    always_comb
    begin
        fill_t k;
        logic [IDX_W-1:0] ki;
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            k  = base - fill_t'(j);
            ki = k[IDX_W-1:0];
            if (fill_t'(j) < cfg.length)
                pos_ok[j] = !pat_care[ki] || (window_next[j] == pat_byte[ki]);
            else
                pos_ok[j] = 1'b1;
        end
    end

    assign hit = !match_seen_reg && (fill_next >= cfg.length) && (&pos_ok);

    always_comb
    begin
        result.push              = accept && (hit || (last_byte && !match_seen_reg));
        result.res.found         = hit;
        result.res.match_address = hit ? (byte_address - addr_t'(base)) : '0;
    end

    // Window contents past the fill count are never compared
    always_ff @(posedge clk)
    begin
        if (accept)
            window_reg <= window_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            match_seen_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                fill_reg       <= '0;
                match_seen_reg <= 1'b0;
            end
            else
            begin
                fill_reg       <= fill_next;
                match_seen_reg <= match_seen_reg || hit;
            end
        end
    end

endmodule

[hdl/mbps_result_queue.sv]
// ----------------------------------------------------------------------------
// Scanner result queue
// Two-entry output queue that decouples the result side from the byte side.
// ----------------------------------------------------------------------------
module mbps_result_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mbps_pkg::result_push_t  push,
    output logic                    full,
    mbps_result_if.source           result
);
    import mbps_pkg::*;

    result_t     entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        pop;

    assign pop  = result.valid && result.ready;
    assign full = (count_reg == 2'd2);

    always_comb
    begin
        count_next = count_reg;
        if (push.push && !pop)
            count_next = count_reg + 2'd1;
        else if (!push.push && pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push.push)
            entry_reg[wr_ptr_reg] <= push.res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    assign result.valid         = (count_reg != 2'd0);
    assign result.found         = entry_reg[rd_ptr_reg].found;
    assign result.match_address = entry_reg[rd_ptr_reg].match_address;
    assign result.last          = 1'b1;

endmodule

[hdl/masked_byte_pattern_scanner_unit.sv]
// Throughput: one byte per cycle while the result queue has room; the window
// shift and masked compare finish in the accept cycle, and a two-entry result
// queue absorbs output stalls.
// Reset: pattern, fill count and match flag clear at once; window bytes are not
// reset. Care mask resets to all ones, length to sixteen; no clearing pass needed.
// ----------------------------------------------------------------------------
// Masked byte pattern scanner
// Finds the first masked pattern match in each region of a byte stream.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  mbps_pkg::cfg_index_t        cfg_index,
    input  logic [mbps_pkg::CFG_W-1:0]  cfg_data,
    mbps_byte_if.sink                   stream,
    mbps_result_if.source               result
);
    import mbps_pkg::*;

    scan_cfg_t    cfg;
    result_push_t push;
    logic         queue_full;
    logic         accept;

    // Hold off bytes only when both queue entries are taken
    assign stream.ready = !queue_full;
    assign accept       = stream.valid && stream.ready;

    mbps_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mbps_match_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .accept       (accept),
        .data_byte    (stream.data_byte),
        .byte_address (stream.byte_address),
        .restart      (stream.restart),
        .last_byte    (stream.last_byte),
        .result       (push)
    );

    mbps_result_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (queue_full),
        .result (result)
    );

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// Masked byte pattern scanner testbench
// Drives regions of bytes into the scanner, some with the pattern planted and
// some broken by restarts, and checks every found / not-found transaction
// against a cycle-free prediction of the window and compare logic. A directed
// table covers length clamping, address wrap, later matches and restarts;
// random phases then sweep the pattern registers, idling and back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
    import mbps_pkg::*;

    localparam int HOLD_CYCLES  = 64;
    localparam int SETTLE       = 8;
    localparam int IDLE_LIMIT   = 2000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 112;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_RESULT
    } check_t;

    typedef struct packed {
        byte_t data;
        addr_t addr;
        logic  restart;
        logic  last_byte;
    } scan_byte_t;

    typedef struct {
        bit         is_write;
        cfg_reg_t   target;
        logic [63:0] value;
        scan_byte_t item;
        check_t     chk;
        result_t    typed;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    cfg_index_t cfg_index;
    logic [CFG_W-1:0] cfg_data;

    mbps_byte_if   stream_ch ();
    mbps_result_if result_ch ();

    masked_byte_pattern_scanner_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stream    (stream_ch),
        .result    (result_ch)
    );

    // Scanner copy: configuration, window and per-region match flag
    logic [CFG_W-1:0]    pat_lo = '0;
    logic [CFG_W-1:0]    pat_hi = '0;
    logic [CARE_W-1:0]   care_bits = '1;
    logic [LENCFG_W-1:0] len_cfg = 5'd16;
    byte_t               win_bytes [MAX_PATTERN];
    int                  win_fill = 0;
    bit                  hit_seen = 0;

    result_t   match_reports [$];
    stim_row_t directed_rows [$];

    check_t  offer_check = CHK_MODEL;
    result_t offer_typed = '0;
    bit      quiet = 0;
    bit      tight_regions = 0;
    bit      long_hold_req = 0;
    int      errors = 0;
    int      phase_items = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int eff_len();
        if (len_cfg == 0)
            return 1;
        if (len_cfg > MAX_PATTERN)
            return MAX_PATTERN;
        return int'(len_cfg);
    endfunction

    function automatic byte_t pat_byte(int k);
        logic [2*CFG_W-1:0] both;
        both = {pat_hi, pat_lo};
        return both[8*k +: 8];
    endfunction

    function automatic void clear_window();
        foreach (win_bytes[i])
            win_bytes[i] = '0;
        win_fill = 0;
    endfunction

    function automatic void apply_reg(cfg_index_t idx, logic [CFG_W-1:0] v);
        case (cfg_reg_t'(idx))
            REG_PATTERN_LOW:    pat_lo = v;
            REG_PATTERN_HIGH:   pat_hi = v;
            REG_CARE_MASK:      care_bits = v[CARE_W-1:0];
            REG_PATTERN_LENGTH: len_cfg = v[LENCFG_W-1:0];
            default: ;
        endcase
    endfunction

    // Shift one byte into the window; returns 1 when a transaction is due
    function automatic bit scan_byte_predict(scan_byte_t it, output result_t res);
        int len;
        bit hit;
        bit got;
        len = eff_len();
        got = 0;
        res = '0;
        if (it.restart)
            clear_window();
        for (int i = MAX_PATTERN - 1; i > 0; i--)
            win_bytes[i] = win_bytes[i-1];
        win_bytes[0] = it.data;
        if (win_fill < MAX_PATTERN)
            win_fill++;
        if (!hit_seen && win_fill >= len)
        begin
            hit = 1;
            for (int k = 0; k < len; k++)
                if (k < PAT_BYTES && care_bits[k] && win_bytes[len-1-k] != pat_byte(k))
                    hit = 0;
            if (hit)
            begin
                hit_seen = 1;
                res.found = 1'b1;
                res.match_address = it.addr - addr_t'(len - 1);
                got = 1;
            end
        end
        if (it.last_byte)
        begin
            if (!hit_seen)
            begin
                res = '0;
                got = 1;
            end
            clear_window();
            hit_seen = 0;
        end
        return got;
    endfunction

    // Track writes, predict on accepted bytes, check accepted results
    always @(posedge clk)
    begin
        result_t res;
        result_t want;
        if (rst_n)
        begin
            if (cfg_we)
                apply_reg(cfg_index, cfg_data);
            if (stream_ch.valid && stream_ch.ready)
            begin
                if (scan_byte_predict({stream_ch.data_byte, stream_ch.byte_address,
                                       stream_ch.restart, stream_ch.last_byte}, res)
                    && offer_check == CHK_MODEL)
                    match_reports.insert(match_reports.size(), res);
                if (offer_check == CHK_RESULT)
                    match_reports.insert(match_reports.size(), offer_typed);
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (match_reports.size() == 0)
                begin
                    $error("unexpected transaction: found=%0b match_address=%h",
                           result_ch.found, result_ch.match_address);
                    errors++;
                end
                else
                begin
                    want = match_reports.pop_front();
                    if (result_ch.found !== want.found)
                    begin
                        $error("found: expected %0b, got %0b", want.found, result_ch.found);
                        errors++;
                    end
                    if (result_ch.match_address !== want.match_address)
                    begin
                        $error("match_address: expected %h, got %h",
                               want.match_address, result_ch.match_address);
                        errors++;
                    end
                    if (result_ch.last !== 1'b1)
                    begin
                        $error("last: expected 1, got %0b", result_ch.last);
                        errors++;
                    end
                end
            end
        end
    end

    // Result side: random stall bursts, one long hold on request
    initial
    begin
        int stall;
        stall = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 0;
                stall = HOLD_CYCLES;
            end
            else if (stall == 0 && !quiet && $urandom_range(0, 5) == 0)
                stall = $urandom_range(1, 7);
            if (stall > 0 || !rst_n)
            begin
                result_ch.ready = 1'b0;
                if (stall > 0)
                    stall--;
            end
            else
                result_ch.ready = 1'b1;
        end
    end

    // Watchdog: count cycles with no transaction on any port
    initial
    begin
        int idle;
        idle = 0;
        @(posedge rst_n);
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((stream_ch.valid && stream_ch.ready) || (result_ch.valid && result_ch.ready)
                || cfg_we)
                idle = 0;
            else
                idle++;
        end
        $display("Regression FAIL");
        $finish;
    end

    task automatic push_byte(scan_byte_t it, check_t chk, result_t typed);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            stream_ch.valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        stream_ch.valid        = 1'b1;
        stream_ch.data_byte    = it.data;
        stream_ch.byte_address = it.addr;
        stream_ch.restart      = it.restart;
        stream_ch.last_byte    = it.last_byte;
        offer_check            = chk;
        offer_typed            = typed;
        do
            @(posedge clk);
        while (!stream_ch.ready);
        @(negedge clk);
        phase_items++;
    endtask

    // Hold the stream until every transaction is back and the block is quiet
    task automatic drain();
        stream_ch.valid = 1'b0;
        offer_check = CHK_MODEL;
        while (match_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t r, logic [CFG_W-1:0] v);
        cfg_we    = 1'b1;
        cfg_index = r;
        cfg_data  = v;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic load_config(logic [63:0] lo, logic [63:0] hi, logic [15:0] care,
                               logic [4:0] len);
        drain();
        write_reg(REG_PATTERN_LOW, lo);
        write_reg(REG_PATTERN_HIGH, hi);
        write_reg(REG_CARE_MASK, 64'(care));
        write_reg(REG_PATTERN_LENGTH, 64'(len));
    endtask

    function automatic addr_t rand_addr();
        return addr_t'({$urandom(), $urandom()});
    endfunction

    function automatic void add_write(cfg_reg_t r, logic [63:0] v);
        stim_row_t row;
        row = '{is_write: 1, target: r, value: v, item: '0, chk: CHK_MODEL, typed: '0};
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void add_byte(byte_t d, addr_t a, logic rs, logic lb, check_t chk,
                                     result_t typed);
        stim_row_t row;
        row = '{is_write: 0, target: REG_PATTERN_LOW, value: '0,
                item: '{d, a, rs, lb}, chk: chk, typed: typed};
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void build_directed();
        addr_t wrap_start;
        wrap_start = 48'hFFFF_FFFF_FFFD;
        // Reset setup: sixteen cared zero bytes, so a one-byte region misses
        add_byte(8'hFF, '0, 1'b0, 1'b1, CHK_RESULT, '0);
        // Zero length acts as one
        add_write(REG_PATTERN_LENGTH, 64'd0);
        add_write(REG_PATTERN_LOW, 64'hAB);
        add_byte(8'hAB, '1, 1'b1, 1'b0, CHK_RESULT, {1'b1, 48'hFFFF_FFFF_FFFF});
        add_byte(8'h00, 48'd1, 1'b0, 1'b1, CHK_NONE, '0);
        add_byte(8'hAB, 48'd5, 1'b0, 1'b1, CHK_RESULT, {1'b1, 48'd5});
        // Oversize length clamps to sixteen; region runs across address zero
        add_write(REG_PATTERN_LENGTH, 64'd31);
        add_write(REG_CARE_MASK, 64'h8001);
        add_write(REG_PATTERN_LOW, 64'h5A);
        add_write(REG_PATTERN_HIGH, 64'hA500_0000_0000_0000);
        add_byte(8'h5A, wrap_start, 1'b1, 1'b0, CHK_MODEL, '0);
        for (int i = 1; i < 15; i++)
            add_byte(byte_t'(i * 17), wrap_start + addr_t'(i), 1'b0, 1'b0, CHK_MODEL, '0);
        add_byte(8'hA5, wrap_start + 48'd15, 1'b0, 1'b1, CHK_RESULT, {1'b1, wrap_start});
        // Two-byte pattern: restart empties the window but keeps the match flag
        add_write(REG_PATTERN_LENGTH, 64'd2);
        add_write(REG_CARE_MASK, 64'h0003);
        add_write(REG_PATTERN_LOW, 64'h2211);
        add_byte(8'h11, 48'd100, 1'b0, 1'b0, CHK_MODEL, '0);
        add_byte(8'h22, 48'd200, 1'b1, 1'b0, CHK_MODEL, '0);
        add_byte(8'h11, 48'd300, 1'b0, 1'b0, CHK_MODEL, '0);
        add_byte(8'h22, 48'd301, 1'b0, 1'b0, CHK_RESULT, {1'b1, 48'd300});
        add_byte(8'h11, 48'd500, 1'b1, 1'b0, CHK_MODEL, '0);
        add_byte(8'h22, 48'd501, 1'b0, 1'b1, CHK_NONE, '0);
    endfunction

    // One region: mostly the pattern planted at a random spot, sometimes broken
    task automatic send_region();
        int len;
        int n;
        int at;
        int brk;
        bit plant;
        addr_t a;
        scan_byte_t it;
        len = eff_len();
        if (tight_regions)
            n = $urandom_range(1, 3);
        else if ($urandom_range(0, 9) == 0)
            n = $urandom_range(1, len);
        else
            n = len + $urandom_range(0, 24);
        plant = (n >= len) && ($urandom_range(0, 9) < 7);
        at = plant ? $urandom_range(0, n - len) : 0;
        brk = -1;
        if ($urandom_range(0, 7) == 0)
            brk = $urandom_range(0, n - 1);
        else if (plant && len > 1 && $urandom_range(0, 5) == 0)
            brk = at + $urandom_range(1, len - 1);
        case ($urandom_range(0, 5))
            0: a = addr_t'($urandom_range(0, 20));
            1: a = '1 - addr_t'($urandom_range(0, 20));
            default: a = rand_addr();
        endcase
        for (int i = 0; i < n; i++)
        begin
            it.data = byte_t'($urandom_range(0, 255));
            if (plant && i >= at && i < at + len && care_bits[i-at])
                it.data = pat_byte(i - at);
            if (i == brk)
                a = rand_addr();
            it.addr      = a;
            it.restart   = (i == brk) || (i == 0 && $urandom_range(0, 3) == 0);
            it.last_byte = (i == n - 1);
            push_byte(it, CHK_MODEL, '0);
            a++;
        end
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = REG_PATTERN_LOW;
        cfg_data               = '0;
        stream_ch.valid        = 1'b0;
        stream_ch.data_byte    = '0;
        stream_ch.byte_address = '0;
        stream_ch.restart      = 1'b0;
        stream_ch.last_byte    = 1'b0;
        clear_window();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        build_directed();
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_write)
            begin
                drain();
                write_reg(directed_rows[i].target, directed_rows[i].value);
            end
            else
                push_byte(directed_rows[i].item, directed_rows[i].chk,
                          directed_rows[i].typed);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: load_config({$urandom(), $urandom()}, {$urandom(), $urandom()},
                               16'hFFFF, 5'd1);
                1: load_config({$urandom(), $urandom()}, {$urandom(), $urandom()},
                               16'hFFFF, 5'd16);
                2: load_config({$urandom(), $urandom()}, {$urandom(), $urandom()},
                               16'h0000, 5'd0);
                3: load_config({$urandom(), $urandom()}, {$urandom(), $urandom()},
                               16'($urandom()), 5'd31);
                4: load_config('1, '1, 16'($urandom()), 5'($urandom_range(1, 16)));
                5: load_config('0, '0, 16'($urandom()), 5'($urandom_range(0, 31)));
                default: load_config({$urandom(), $urandom()}, {$urandom(), $urandom()},
                                     16'($urandom()), 5'($urandom_range(0, 31)));
            endcase
            quiet = (ph == PHASES - 1);
            // Every region hits on its first byte here: stall the results so the block backs up
            tight_regions = (ph == 2);
            if (ph == 2)
                long_hold_req = 1;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
                send_region();
        end
        drain();

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
